### sv/gpmb_pkg.sv
package gpmb_pkg;

  localparam int RATE_W   = 16;
  localparam int AMOUNT_W = 22;
  localparam int MS_W     = 16;
  localparam int DIR_W    = 3;
  localparam int DIST_W   = RATE_W + MS_W;
  localparam int OUT_W    = 48;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic [CFG_AW-1:0] CFG_RATE    = 4'd0;
  localparam logic [CFG_AW-1:0] CFG_AMOUNT  = 4'd1;
  localparam logic [CFG_AW-1:0] CFG_WEST    = 4'd2;
  localparam logic [CFG_AW-1:0] CFG_REVERSE = 4'd3;

  localparam logic [RATE_W-1:0]   RATE_RESET   = 16'd229;
  localparam logic [AMOUNT_W-1:0] AMOUNT_RESET = 22'd720896;

  localparam logic [DIR_W-1:0] DIR_NORTH = 3'd0;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd1;
  localparam logic [DIR_W-1:0] DIR_EAST  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_WEST  = 3'd3;

  typedef enum logic [2:0] {
    MV_DEC_UP,
    MV_DEC_DOWN,
    MV_RA_DOWN,
    MV_RA_UP,
    MV_BAD
  } move_t;

  typedef struct packed {
    logic [RATE_W-1:0]   rate;
    logic [AMOUNT_W-1:0] amount;
    logic                west;
    logic                reverse;
  } cfg_t;

  typedef struct packed {
    move_t             mv;
    logic [DIST_W-1:0] move_len;
  } stage_t;

endpackage

### sv/gpmb_scale.sv
module gpmb_scale import gpmb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DIR_W-1:0] dir,
  input  logic [MS_W-1:0]  pulse_ms,
  output logic             stg_valid,
  output stage_t           stg,
  input  logic             stg_take
);

  logic   valid_r;
  stage_t stage_r;
  stage_t stage_nxt;
  logic   swap;

  assign swap = cfg.west & cfg.reverse;

  always_comb begin
    stage_nxt.move_len = DIST_W'(cfg.rate) * DIST_W'(pulse_ms);
    unique case (dir)
      DIR_NORTH: stage_nxt.mv = swap ? MV_DEC_DOWN : MV_DEC_UP;
      DIR_SOUTH: stage_nxt.mv = swap ? MV_DEC_UP : MV_DEC_DOWN;
      DIR_EAST:  stage_nxt.mv = MV_RA_DOWN;
      DIR_WEST:  stage_nxt.mv = MV_RA_UP;
      default:   stage_nxt.mv = MV_BAD;
    endcase
  end

  assign in_ready  = !valid_r || stg_take;
  assign stg_valid = valid_r;
  assign stg       = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

### sv/gpmb_track.sv
module gpmb_track import gpmb_pkg::*; #(
  parameter int POS_WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic                stg_valid,
  input  stage_t              stg,
  output logic                stg_take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    ra_offset,
  output logic [OUT_W-1:0]    dec_offset,
  output logic                bad_direction
);

  localparam int SW = POS_WIDTH + 3;
  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  function automatic logic signed [POS_WIDTH-1:0] sat_add(
    input logic signed [POS_WIDTH-1:0] a,
    input logic signed [SW-1:0]        b
  );
    logic signed [SW-1:0] s;
    s = SW'(a) + b;
    if (s > SW'(POS_MAX)) begin
      sat_add = POS_MAX;
    end else if (s < SW'(POS_MIN)) begin
      sat_add = POS_MIN;
    end else begin
      sat_add = $signed(s[POS_WIDTH-1:0]);
    end
  endfunction

  logic signed [POS_WIDTH-1:0] ra_r, idx_r, up_r;
  logic signed [POS_WIDTH-1:0] ra_nxt, idx_nxt, up_nxt;
  logic signed [POS_WIDTH-1:0] idx_up, idx_down, top;
  logic signed [SW-1:0]        dist_s, amount_s;
  logic                        nonzero;
  logic                        out_valid_r;
  logic [OUT_W-1:0]            ra_out_r, dec_out_r;
  logic                        bad_r;
  logic                        load;

  assign dist_s   = $signed({{(SW-DIST_W){1'b0}}, stg.move_len});
  assign amount_s = $signed({{(SW-AMOUNT_W){1'b0}}, amount});
  assign nonzero  = (stg.move_len != '0);
  assign idx_up   = sat_add(idx_r, dist_s);
  assign idx_down = sat_add(idx_r, -dist_s);
  assign top      = sat_add(idx_down, amount_s);

  always_comb begin
    ra_nxt  = ra_r;
    idx_nxt = idx_r;
    up_nxt  = up_r;
    case (stg.mv)
      MV_RA_UP:   ra_nxt = sat_add(ra_r, dist_s);
      MV_RA_DOWN: ra_nxt = sat_add(ra_r, -dist_s);
      MV_DEC_UP: begin
        idx_nxt = idx_up;
        if (nonzero && idx_up > up_r) begin
          up_nxt = idx_up;
        end
      end
      MV_DEC_DOWN: begin
        idx_nxt = idx_down;
        if (nonzero && top < up_r) begin
          up_nxt = top;
        end
      end
      default: ;
    endcase
  end

  assign stg_take = !out_valid_r || out_ready;
  assign load     = stg_valid && stg_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ra_r        <= '0;
      idx_r       <= '0;
      up_r        <= POS_WIDTH'(AMOUNT_RESET);
    end else begin
      if (stg_take) begin
        out_valid_r <= stg_valid;
      end
      if (load) begin
        ra_r  <= ra_nxt;
        idx_r <= idx_nxt;
        up_r  <= up_nxt;
      end
    end
    if (load) begin
      ra_out_r  <= OUT_W'(ra_nxt);
      dec_out_r <= OUT_W'(up_nxt);
      bad_r     <= (stg.mv == MV_BAD);
    end
  end

  assign out_valid     = out_valid_r;
  assign ra_offset     = ra_out_r;
  assign dec_offset    = dec_out_r;
  assign bad_direction = bad_r;

endmodule

### sv/guide_pulse_mount_backlash.sv
// channel   direction  request carries
// in_       slave      tuser: direction; tdata: pulse_ms
// out_      master     tdata: ra_offset, dec_offset; tuser: bad_direction
// cfg_      slave      register index and write data, always ready
//
// one request per cycle sustained while the output is not stalled; the scale stage
// forms rate times duration in the multiplier and registers it, the track stage
// then updates the mount state and loads the result register
// synchronous active-low reset clears the handshake state and the mount positions
// a stalled output holds its result while one more request waits in the input stage
module guide_pulse_mount_backlash import gpmb_pkg::*; #(
  parameter int POS_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // pulse_ms
  input  logic [2:0]        in_tuser,   // direction
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,  // ra_offset, dec_offset
  output logic [0:0]        out_tuser,  // bad_direction
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t             cfg_r;
  logic             stg_valid;
  stage_t           stg;
  logic             stg_take;
  logic [OUT_W-1:0] ra_offset, dec_offset;
  logic             bad_direction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate    <= RATE_RESET;
      cfg_r.amount  <= AMOUNT_RESET;
      cfg_r.west    <= 1'b0;
      cfg_r.reverse <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_RATE:    cfg_r.rate    <= cfg_data[RATE_W-1:0];
        CFG_AMOUNT:  cfg_r.amount  <= cfg_data[AMOUNT_W-1:0];
        CFG_WEST:    cfg_r.west    <= cfg_data[0];
        CFG_REVERSE: cfg_r.reverse <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gpmb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .dir      (in_tuser),
    .pulse_ms (in_tdata),
    .stg_valid(stg_valid),
    .stg      (stg),
    .stg_take (stg_take)
  );

  gpmb_track #(
    .POS_WIDTH(POS_WIDTH)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .amount       (cfg_r.amount),
    .stg_valid    (stg_valid),
    .stg          (stg),
    .stg_take     (stg_take),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .ra_offset    (ra_offset),
    .dec_offset   (dec_offset),
    .bad_direction(bad_direction)
  );

  assign out_tdata = {dec_offset, ra_offset};
  assign out_tuser = bad_direction;

  a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid && stg_take && stg.mv == MV_BAD) |=> (out_tvalid && out_tuser[0]))
    else $error("bad direction not flagged");

  a_ra_keeps_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid && stg_take && out_tvalid && (stg.mv == MV_RA_UP || stg.mv == MV_RA_DOWN))
    |=> $stable(out_tdata[95:48]))
    else $error("ra move changed dec offset");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && stg_valid) |-> !in_tready)
    else $error("input accepted while pipeline full");

endmodule

### tb/sv/mount_offset_checker.sv
module mount_offset_checker import gpmb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [MS_W-1:0]   in_tdata,   // pulse_ms
  input  logic [DIR_W-1:0]  in_tuser,   // direction
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [95:0]       out_tdata,  // ra_offset, dec_offset
  input  logic [0:0]        out_tuser,  // bad_direction
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                pending,
  output int                fail_count,
  output int                results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_MIN = -POS_MAX - 1;

  typedef struct packed {
    logic [OUT_W-1:0] ra;
    logic [OUT_W-1:0] dec;
    logic             bad;
  } offsets_t;

  cfg_t     mount_cfg;
  longint   ra_pos;
  longint   dec_idx;
  longint   dec_upper;
  offsets_t expected_offsets[$];
  int       errs = 0;
  int       seen = 0;

  function automatic longint clamp_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > POS_MAX) return POS_MAX;
    if (s < POS_MIN) return POS_MIN;
    return s;
  endfunction

  function automatic offsets_t apply_pulse(input logic [DIR_W-1:0] dir,
                                           input logic [MS_W-1:0] ms);
    logic [63:0]      prod;
    longint           d;
    longint           top;
    logic [DIR_W-1:0] eff;
    move_t            mv;
    offsets_t         r;
    prod = mount_cfg.rate * ms;
    d = longint'(prod);
    eff = dir;
    if (mount_cfg.west && mount_cfg.reverse) begin
      if (dir == DIR_NORTH) eff = DIR_SOUTH;
      else if (dir == DIR_SOUTH) eff = DIR_NORTH;
    end
    case (eff)
      DIR_NORTH: mv = MV_DEC_UP;
      DIR_SOUTH: mv = MV_DEC_DOWN;
      DIR_EAST:  mv = MV_RA_DOWN;
      DIR_WEST:  mv = MV_RA_UP;
      default:   mv = MV_BAD;
    endcase
    case (mv)
      MV_DEC_UP: begin
        if (d != 0) begin
          dec_idx = clamp_add(dec_idx, d);
          if (dec_idx > dec_upper) dec_upper = dec_idx;
        end
      end
      MV_DEC_DOWN: begin
        if (d != 0) begin
          dec_idx = clamp_add(dec_idx, -d);
          top = clamp_add(dec_idx, longint'(mount_cfg.amount));
          if (top < dec_upper) dec_upper = top;
        end
      end
      MV_RA_DOWN: ra_pos = clamp_add(ra_pos, -d);
      MV_RA_UP:   ra_pos = clamp_add(ra_pos, d);
      default: ;
    endcase
    r.ra  = OUT_W'(ra_pos);
    r.dec = OUT_W'(dec_upper);
    r.bad = (mv == MV_BAD);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    offsets_t want;
    offsets_t got;
    if (!rst_n) begin
      mount_cfg = '{rate: RATE_RESET, amount: AMOUNT_RESET, west: 1'b0, reverse: 1'b1};
      ra_pos    = 0;
      dec_idx   = 0;
      dec_upper = longint'(AMOUNT_RESET);
      expected_offsets.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.ra  = out_tdata[OUT_W-1:0];
        got.dec = out_tdata[2*OUT_W-1:OUT_W];
        got.bad = out_tuser[0];
        if (expected_offsets.size() == 0) begin
          errs++;
          $error("result with no request pending: ra_offset %0d dec_offset %0d bad_direction %b",
                 $signed(got.ra), $signed(got.dec), got.bad);
        end else begin
          want = expected_offsets.pop_front();
          seen++;
          if (got.ra !== want.ra) begin
            errs++;
            $error("ra_offset: expected %0d, got %0d", $signed(want.ra), $signed(got.ra));
          end
          if (got.dec !== want.dec) begin
            errs++;
            $error("dec_offset: expected %0d, got %0d", $signed(want.dec), $signed(got.dec));
          end
          if (got.bad !== want.bad) begin
            errs++;
            $error("bad_direction: expected %b, got %b", want.bad, got.bad);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_RATE:    mount_cfg.rate    = cfg_data[RATE_W-1:0];
          CFG_AMOUNT:  mount_cfg.amount  = cfg_data[AMOUNT_W-1:0];
          CFG_WEST:    mount_cfg.west    = cfg_data[0];
          CFG_REVERSE: mount_cfg.reverse = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_offsets.push_back(apply_pulse(in_tuser, in_tdata));
    end
    pending         <= expected_offsets.size();
    fail_count      <= errs;
    results_checked <= seen;
  end

endmodule

### tb/sv/guide_pulse_mount_backlash_tb.sv
module guide_pulse_mount_backlash_tb import gpmb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_PULSES  = 150;
  localparam logic [MS_W-1:0]     MS_MAX     = '1;
  localparam logic [RATE_W-1:0]   RATE_MAX   = '1;
  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [MS_W-1:0]   in_tdata   = '0;
  logic [DIR_W-1:0]  in_tuser   = DIR_NORTH;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [95:0]       out_tdata;
  logic [0:0]        out_tuser;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_addr   = CFG_RATE;
  logic [CFG_DW-1:0] cfg_data   = '0;

  logic             idle_on     = 1'b1;
  logic [DIR_W-1:0] last_dir    = DIR_NORTH;
  int               cycle_count = 0;
  int               pulses_sent = 0;
  int               reg_writes  = 0;
  int               settings    = 0;
  int               pending;
  int               fail_count;
  int               results_checked;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  guide_pulse_mount_backlash i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  mount_offset_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .fail_count      (fail_count),
    .results_checked (results_checked)
  );

  always @(posedge clk) out_tready <= !idle_on || ($urandom_range(99) >= 30);

  task automatic send_pulse(input logic [DIR_W-1:0] dir, input logic [MS_W-1:0] ms);
    while (idle_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= dir;
    in_tdata  <= ms;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pulses_sent++;
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic load_registers(input logic [CFG_DW-1:0] rate, input logic [CFG_DW-1:0] amount,
                                input logic [CFG_DW-1:0] west, input logic [CFG_DW-1:0] rev,
                                input logic stray);
    wait_quiet();
    write_reg(CFG_RATE, rate);
    write_reg(CFG_AMOUNT, amount);
    write_reg(CFG_WEST, west);
    write_reg(CFG_REVERSE, rev);
    if (stray) write_reg(CFG_AW'($urandom_range(15, CFG_REVERSE + 1)), $urandom());
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // unused upper bits filled with noise, they must be dropped
  function automatic logic [CFG_DW-1:0] with_junk(input int unsigned value, input int width);
    logic [CFG_DW-1:0] r;
    r = $urandom();
    r = (r >> width) << width;
    return r | value;
  endfunction

  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(5))
      0:       return '0;
      1:       return MS_MAX;
      2, 3:    return MS_W'($urandom_range(3000));
      default: return MS_W'($urandom_range(MS_MAX));
    endcase
  endfunction

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [DIR_W-1:0]  dir;
    logic              raw;
    int unsigned       rate;
    int unsigned       amount;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero moves, play band, both ra directions, bad codes
    send_pulse(DIR_NORTH, '0);
    send_pulse(DIR_SOUTH, '0);
    send_pulse(DIR_NORTH, MS_W'(1000));
    send_pulse(DIR_NORTH, MS_W'(5000));
    send_pulse(DIR_SOUTH, MS_W'(2000));
    send_pulse(DIR_SOUTH, MS_MAX);
    send_pulse(DIR_EAST, MS_MAX);
    send_pulse(DIR_WEST, MS_MAX);
    send_pulse(DIR_WEST, MS_W'(1));
    for (int k = DIR_WEST + 1; k < 8; k++) send_pulse(DIR_W'(k), MS_MAX);

    // west side with reversal: north and south swap; then settings without the swap
    load_registers(with_junk(RATE_MAX, RATE_W), with_junk(AMOUNT_RESET, AMOUNT_W),
                   with_junk(1, 1), with_junk(1, 1), 1'b1);
    send_pulse(DIR_NORTH, MS_MAX);
    send_pulse(DIR_SOUTH, MS_MAX);
    send_pulse(DIR_EAST, MS_W'(1));
    send_pulse(DIR_WEST, '0);
    load_registers(1, AMOUNT_MAX, 1, 0, 1'b1);
    send_pulse(DIR_NORTH, MS_W'(40000));
    send_pulse(DIR_SOUTH, MS_W'(1));
    load_registers(RATE_MAX, 0, 0, 0, 1'b0);
    send_pulse(DIR_NORTH, MS_MAX);
    send_pulse(DIR_SOUTH, MS_MAX);
    load_registers(0, AMOUNT_MAX, 0, 1, 1'b0);
    send_pulse(DIR_NORTH, MS_MAX);
    send_pulse(DIR_WEST, MS_MAX);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != 4);
      case ($urandom_range(5))
        0:       rate = 0;
        1:       rate = RATE_MAX;
        2, 3:    rate = $urandom_range(400, 1);
        default: rate = $urandom_range(RATE_MAX);
      endcase
      case ($urandom_range(4))
        0:       amount = 0;
        1:       amount = AMOUNT_MAX;
        2, 3:    amount = $urandom_range(2000000, 100);
        default: amount = $urandom_range(AMOUNT_MAX);
      endcase
      raw = $urandom_range(1);
      load_registers(raw ? with_junk(rate, RATE_W) : rate,
                     raw ? with_junk(amount, AMOUNT_W) : amount,
                     raw ? with_junk($urandom_range(1), 1) : $urandom_range(1),
                     raw ? with_junk($urandom_range(1), 1) : $urandom_range(1),
                     $urandom_range(3) == 0);
      for (int i = 0; i < PHASE_PULSES; i++) begin
        if ((p == 1 && i == 60) || $urandom_range(199) == 0) wait_quiet();
        if ($urandom_range(99) < 50) dir = last_dir;
        else if ($urandom_range(99) < 85) dir = DIR_W'($urandom_range(DIR_WEST));
        else dir = DIR_W'($urandom_range(7));
        last_dir = dir;
        send_pulse(dir, pick_ms());
      end
    end

    idle_on = 1'b0;
    wait_quiet();
    repeat (8) @(posedge clk);
    $display("covered %0d guide pulses, %0d results compared, play band and bad codes",
             pulses_sent, results_checked);
    $display("%0d register writes over %0d settings, pier side swap, zero and full rate and play",
             reg_writes, settings);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
